// ===== src/roi_mp_pkg.sv =====
// ----------------------------------------------------------------------------
// roi_mp_pkg
// Shared types and constants of the ROI max pooling block.
// ----------------------------------------------------------------------------
package roi_mp_pkg;

	localparam int DEF_CHANNELS   = 16;
	localparam int DEF_MAX_MAP_H  = 64;
	localparam int DEF_MAX_MAP_W  = 64;
	localparam int DEF_MAX_POOLED = 8;

	localparam int FEAT_W      = 16;
	localparam int CH_IN_W     = 4;
	localparam int POS_W       = 6;
	localparam int BOX_W       = 16;
	localparam int COORD_W     = 18;
	localparam int SIZE_W      = 18;
	localparam int BIN_W       = 3;
	localparam int MAP_CFG_W   = 7;
	localparam int POOL_CFG_W  = 4;
	localparam int SCALE_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int PROD_W      = 33;
	localparam int QUEUE_DEPTH = 2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_POOL  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAP_H,
		CFG_MAP_W,
		CFG_POOL_H,
		CFG_POOL_W,
		CFG_SCALE
	} cfg_idx_t;

	typedef struct packed {
		logic                      op;
		logic [CH_IN_W-1:0]        ch;
		logic [POS_W-1:0]          row;
		logic [POS_W-1:0]          col;
		logic signed [FEAT_W-1:0]  value;
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
		logic [SIZE_W-1:0]         rw;
		logic [SIZE_W-1:0]         rh;
	} cmd_t;

endpackage

// ===== src/roi_mp_if.sv =====
// ----------------------------------------------------------------------------
// roi_mp_if
// Request and result channel interfaces of the ROI max pooling block.
// ----------------------------------------------------------------------------
interface roi_mp_req_if import roi_mp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic [CH_IN_W-1:0]       channel_index;
	logic [POS_W-1:0]         row;
	logic [POS_W-1:0]         col;
	logic signed [FEAT_W-1:0] feature_value;
	logic signed [BOX_W-1:0]  box_x0;
	logic signed [BOX_W-1:0]  box_y0;
	logic signed [BOX_W-1:0]  box_x1;
	logic signed [BOX_W-1:0]  box_y1;

	modport source (output valid, operation, channel_index, row, col, feature_value,
		box_x0, box_y0, box_x1, box_y1, input ready);
	modport sink (input valid, operation, channel_index, row, col, feature_value,
		box_x0, box_y0, box_x1, box_y1, output ready);
endinterface

interface roi_mp_rsp_if import roi_mp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [FEAT_W-1:0] pooled_value;
	logic [CH_IN_W-1:0]       out_channel;
	logic [BIN_W-1:0]         bin_row;
	logic [BIN_W-1:0]         bin_col;
	logic                     last;

	modport source (output valid, pooled_value, out_channel, bin_row, bin_col, last,
		input ready);
	modport sink (input valid, pooled_value, out_channel, bin_row, bin_col, last,
		output ready);
endinterface

// ===== src/roi_max_pooling_top.sv =====
// ----------------------------------------------------------------------------
// roi_max_pooling_top
// Region-of-interest max pooling over a stored feature map.
// ----------------------------------------------------------------------------
// req carries write items (store one feature) and pool items (one box, one
// channel). rsp returns pooled_height x pooled_width results per pool item in
// row-major bin order, last set on the final bin. Write items give no result.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while idle, as the block does not enforce this. The front
// scales and rounds the box in two pipeline stages and hands a command through
// a two-entry queue, so it keeps taking items while the back is busy or a
// result waits on rsp, until the queue fills. A write is stored after it
// passes the two front stages and the queue. Per bin the back works out four
// bounds by serial division, then makes one memory read per feature of the
// bin and offers the result. The feature store has a single read port.
// Reset clears the control state and restores the register defaults; the
// feature store is not cleared and must be written before it is pooled.
// When rsp stalls, the result holds and the back waits; the queue then fills
// and req.ready drops.
// ----------------------------------------------------------------------------
module roi_max_pooling_top import roi_mp_pkg::*; #(
	parameter int CHANNELS   = DEF_CHANNELS,
	parameter int MAX_MAP_H  = DEF_MAX_MAP_H,
	parameter int MAX_MAP_W  = DEF_MAX_MAP_W,
	parameter int MAX_POOLED = DEF_MAX_POOLED
) (
	input  logic                  clk,
	input  logic                  arst_n,
	roi_mp_req_if.sink            req,
	roi_mp_rsp_if.source          rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int HB_W = $clog2(MAX_MAP_H + 1);
	localparam int WB_W = $clog2(MAX_MAP_W + 1);

	logic [MAP_CFG_W-1:0]  map_height_q, map_width_q;
	logic [POOL_CFG_W-1:0] pooled_height_q, pooled_width_q;
	logic [SCALE_W-1:0]    coord_scale_q;
	logic [HB_W-1:0]       map_h;
	logic [WB_W-1:0]       map_w;
	logic [POOL_CFG_W-1:0] pool_h, pool_w;
	logic                  push_valid, push_ready, pop_valid, pop_ready;
	cmd_t                  push_cmd, pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_height_q    <= MAP_CFG_W'(64);
			map_width_q     <= MAP_CFG_W'(64);
			pooled_height_q <= POOL_CFG_W'(7);
			pooled_width_q  <= POOL_CFG_W'(7);
			coord_scale_q   <= SCALE_W'(4096);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_H:  map_height_q    <= cfg_wdata[MAP_CFG_W-1:0];
				CFG_MAP_W:  map_width_q     <= cfg_wdata[MAP_CFG_W-1:0];
				CFG_POOL_H: pooled_height_q <= cfg_wdata[POOL_CFG_W-1:0];
				CFG_POOL_W: pooled_width_q  <= cfg_wdata[POOL_CFG_W-1:0];
				CFG_SCALE:  coord_scale_q   <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign map_h = (map_height_q == '0) ? HB_W'(1)
		: ((int'(map_height_q) > MAX_MAP_H) ? HB_W'(MAX_MAP_H) : HB_W'(map_height_q));
	assign map_w = (map_width_q == '0) ? WB_W'(1)
		: ((int'(map_width_q) > MAX_MAP_W) ? WB_W'(MAX_MAP_W) : WB_W'(map_width_q));
	assign pool_h = (pooled_height_q == '0) ? POOL_CFG_W'(1)
		: ((int'(pooled_height_q) > MAX_POOLED) ? POOL_CFG_W'(MAX_POOLED) : pooled_height_q);
	assign pool_w = (pooled_width_q == '0) ? POOL_CFG_W'(1)
		: ((int'(pooled_width_q) > MAX_POOLED) ? POOL_CFG_W'(MAX_POOLED) : pooled_width_q);

	roi_mp_front #(.CHANNELS(CHANNELS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.coord_scale(coord_scale_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	roi_mp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	roi_mp_back #(
		.CHANNELS  (CHANNELS),
		.MAX_MAP_H (MAX_MAP_H),
		.MAX_MAP_W (MAX_MAP_W),
		.MAX_POOLED(MAX_POOLED)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd  (pop_cmd),
		.map_h    (map_h),
		.map_w    (map_w),
		.pool_h   (pool_h),
		.pool_w   (pool_w),
		.rsp      (rsp)
	);

endmodule

// ===== src/roi_mp_front.sv =====
// ----------------------------------------------------------------------------
// roi_mp_front
// Accepts requests, scales and rounds box corners, forms queue commands.
// ----------------------------------------------------------------------------
module roi_mp_front import roi_mp_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	roi_mp_req_if.sink         req,
	input  logic [SCALE_W-1:0] coord_scale,
	output logic               push_valid,
	input  logic               push_ready,
	output cmd_t               push_cmd
);

	function automatic logic signed [COORD_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] sum;
		logic [COORD_W-1:0] r;
		begin
			mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
			sum = mag + PROD_W'(32768);
			r = COORD_W'(sum[PROD_W-1:16]);
			return p[PROD_W-1] ? -$signed(r) : $signed(r);
		end
	endfunction

	logic                      s1_valid, s2_valid, en1, en2;
	logic                      op_s1, op_s2;
	logic [CH_IN_W-1:0]        ch_s1, ch_s2;
	logic [CH_IN_W-1:0]        ch_wrap;
	logic [POS_W-1:0]          row_s1, row_s2, col_s1, col_s2;
	logic signed [FEAT_W-1:0]  val_s1, val_s2;
	logic signed [PROD_W-1:0]  px0_s1, py0_s1, px1_s1, py1_s1;
	logic signed [COORD_W-1:0] cx0_s2, cy0_s2, cx1_s2, cy1_s2;
	logic signed [SIZE_W:0]    dx, dy;
	logic signed [SCALE_W:0]   scale_s;

	assign scale_s = $signed({1'b0, coord_scale});
	assign en2 = !s2_valid || push_ready;
	assign en1 = !s1_valid || en2;
	assign req.ready = en1;

	// channel wrap as a constant table over every channel code
	always_comb begin
		ch_wrap = '0;
		for (int i = 0; i < (1 << CH_IN_W); i++) begin
			if (req.channel_index == CH_IN_W'(i)) ch_wrap = CH_IN_W'(i % CHANNELS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			if (en1) s1_valid <= req.valid;
			if (en2) s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req.valid) begin
			op_s1  <= req.operation;
			ch_s1  <= ch_wrap;
			row_s1 <= req.row;
			col_s1 <= req.col;
			val_s1 <= req.feature_value;
			px0_s1 <= req.box_x0 * scale_s;
			py0_s1 <= req.box_y0 * scale_s;
			px1_s1 <= req.box_x1 * scale_s;
			py1_s1 <= req.box_y1 * scale_s;
		end
		if (en2 && s1_valid) begin
			op_s2  <= op_s1;
			ch_s2  <= ch_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			val_s2 <= val_s1;
			cx0_s2 <= round_q16(px0_s1);
			cy0_s2 <= round_q16(py0_s1);
			cx1_s2 <= round_q16(px1_s1);
			cy1_s2 <= round_q16(py1_s1);
		end
	end

	assign dx = (SIZE_W+1)'(cx1_s2) - (SIZE_W+1)'(cx0_s2) + (SIZE_W+1)'(1);
	assign dy = (SIZE_W+1)'(cy1_s2) - (SIZE_W+1)'(cy0_s2) + (SIZE_W+1)'(1);

	always_comb begin
		push_cmd.op    = op_s2;
		push_cmd.ch    = ch_s2;
		push_cmd.row   = row_s2;
		push_cmd.col   = col_s2;
		push_cmd.value = val_s2;
		push_cmd.x0    = cx0_s2;
		push_cmd.y0    = cy0_s2;
		push_cmd.rw    = (dx < (SIZE_W+1)'(1)) ? SIZE_W'(1) : dx[SIZE_W-1:0];
		push_cmd.rh    = (dy < (SIZE_W+1)'(1)) ? SIZE_W'(1) : dy[SIZE_W-1:0];
	end

	assign push_valid = s2_valid;

endmodule

// ===== src/roi_mp_queue.sv =====
// ----------------------------------------------------------------------------
// roi_mp_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module roi_mp_queue import roi_mp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             buf_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) buf_q[wr_q] <= push_cmd;
	end

endmodule

// ===== src/roi_mp_back.sv =====
// ----------------------------------------------------------------------------
// roi_mp_back
// Feature store, bin bound divider and max scan over each bin.
// ----------------------------------------------------------------------------
module roi_mp_back import roi_mp_pkg::*; #(
	parameter int CHANNELS   = DEF_CHANNELS,
	parameter int MAX_MAP_H  = DEF_MAX_MAP_H,
	parameter int MAX_MAP_W  = DEF_MAX_MAP_W,
	parameter int MAX_POOLED = DEF_MAX_POOLED,
	localparam int HB_W = $clog2(MAX_MAP_H + 1),
	localparam int WB_W = $clog2(MAX_MAP_W + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  cmd_t                  pop_cmd,
	input  logic [HB_W-1:0]       map_h,
	input  logic [WB_W-1:0]       map_w,
	input  logic [POOL_CFG_W-1:0] pool_h,
	input  logic [POOL_CFG_W-1:0] pool_w,
	roi_mp_rsp_if.source          rsp
);

	localparam int DEPTH  = CHANNELS * MAX_MAP_H * MAX_MAP_W;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NUM_W  = SIZE_W + POOL_CFG_W - 1;
	localparam int CNT_W  = $clog2(NUM_W);
	localparam int SUM_W  = NUM_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_DIV, ST_BOUND, ST_CHECK, ST_SCAN, ST_DRAIN, ST_EMIT
	} state_t;

	state_t                    state_q;
	cmd_t                      cmd_q;
	logic [BIN_W-1:0]          h_q, w_q;
	logic [1:0]                step_q;
	logic [NUM_W-1:0]          num_q, num_sel;
	logic [POOL_CFG_W:0]       rem_q, trial;
	logic [CNT_W-1:0]          cnt_q;
	logic [HB_W-1:0]           hs_q, he_q, y_q;
	logic [WB_W-1:0]           ws_q, we_q, x_q;
	logic signed [FEAT_W-1:0]  best_q, rdata_s1;
	logic                      first_q, rd_s1;
	logic signed [FEAT_W-1:0]  mem_q [DEPTH];
	logic [POOL_CFG_W-1:0]     div_d, h_p1, w_p1;
	logic                      ge, is_last, mem_we, rd_en, row_dim;
	logic signed [SUM_W-1:0]   sum, lim, bound;
	logic [ADDR_W-1:0]         waddr, raddr;

	assign row_dim = !step_q[1];
	assign h_p1    = POOL_CFG_W'(h_q) + 1'b1;
	assign w_p1    = POOL_CFG_W'(w_q) + 1'b1;
	assign div_d   = row_dim ? pool_h : pool_w;

	always_comb begin
		case (step_q)
			2'd0: num_sel = NUM_W'(h_q) * NUM_W'(cmd_q.rh);
			2'd1: num_sel = NUM_W'(h_p1) * NUM_W'(cmd_q.rh) + NUM_W'(pool_h) - 1'b1;
			2'd2: num_sel = NUM_W'(w_q) * NUM_W'(cmd_q.rw);
			default: num_sel = NUM_W'(w_p1) * NUM_W'(cmd_q.rw) + NUM_W'(pool_w) - 1'b1;
		endcase
	end

	assign trial = {rem_q[POOL_CFG_W-1:0], num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, div_d};

	assign sum   = (row_dim ? SUM_W'(cmd_q.y0) : SUM_W'(cmd_q.x0)) + $signed({2'b0, num_q});
	assign lim   = row_dim ? $signed(SUM_W'(map_h)) : $signed(SUM_W'(map_w));
	assign bound = (sum < 0) ? '0 : ((sum > lim) ? lim : sum);

	assign is_last = (POOL_CFG_W'(h_q) == pool_h - 1'b1) && (POOL_CFG_W'(w_q) == pool_w - 1'b1);

	assign pop_ready = state_q == ST_IDLE;
	assign mem_we = pop_valid && pop_ready && pop_cmd.op == OP_WRITE
		&& int'(pop_cmd.row) < MAX_MAP_H && int'(pop_cmd.col) < MAX_MAP_W;
	assign rd_en = state_q == ST_SCAN;
	assign waddr = (ADDR_W'(pop_cmd.ch) * ADDR_W'(MAX_MAP_H) + ADDR_W'(pop_cmd.row))
		* ADDR_W'(MAX_MAP_W) + ADDR_W'(pop_cmd.col);
	assign raddr = (ADDR_W'(cmd_q.ch) * ADDR_W'(MAX_MAP_H) + ADDR_W'(y_q))
		* ADDR_W'(MAX_MAP_W) + ADDR_W'(x_q);

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[waddr] <= pop_cmd.value;
		if (rd_en) rdata_s1 <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (pop_valid && pop_cmd.op == OP_POOL) begin
						cmd_q   <= pop_cmd;
						h_q     <= '0;
						w_q     <= '0;
						step_q  <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					num_q   <= num_sel;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? trial - {1'b0, div_d} : trial;
					num_q <= {num_q[NUM_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) state_q <= ST_BOUND;
				end
				ST_BOUND: begin
					case (step_q)
						2'd0: hs_q <= HB_W'(bound);
						2'd1: he_q <= HB_W'(bound);
						2'd2: ws_q <= WB_W'(bound);
						default: we_q <= WB_W'(bound);
					endcase
					step_q  <= step_q + 1'b1;
					state_q <= (step_q == 2'd3) ? ST_CHECK : ST_LOAD;
				end
				ST_CHECK: begin
					if (he_q > hs_q && we_q > ws_q) begin
						y_q     <= hs_q;
						x_q     <= ws_q;
						first_q <= 1'b1;
						state_q <= ST_SCAN;
					end else begin
						best_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_SCAN: begin
					if (x_q == we_q - 1'b1) begin
						x_q <= ws_q;
						if (y_q == he_q - 1'b1) state_q <= ST_DRAIN;
						else y_q <= y_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (rsp.ready) begin
						step_q <= '0;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_LOAD;
							if (POOL_CFG_W'(w_q) == pool_w - 1'b1) begin
								w_q <= '0;
								h_q <= h_q + 1'b1;
							end else begin
								w_q <= w_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (rd_s1 && (first_q || rdata_s1 > best_q)) begin
				best_q  <= rdata_s1;
				first_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = state_q == ST_EMIT;
	assign rsp.pooled_value = best_q;
	assign rsp.out_channel  = cmd_q.ch;
	assign rsp.bin_row      = h_q;
	assign rsp.bin_col      = w_q;
	assign rsp.last         = is_last;

endmodule

// ===== src/roi_mp_checker.sv =====
// ----------------------------------------------------------------------------
// roi_mp_checker
// Port-level checks on the result channel of the pooling block.
// ----------------------------------------------------------------------------
module roi_mp_checker import roi_mp_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [FEAT_W-1:0] pooled_value,
	input logic [CH_IN_W-1:0]       out_channel,
	input logic [BIN_W-1:0]         bin_row,
	input logic [BIN_W-1:0]         bin_col,
	input logic                     last
);

	// no result while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable({pooled_value, out_channel, bin_row, bin_col, last}))
		else $error("result changed while stalled");

	// each bin needs its bounds worked out, so results never come back to back
	a_bin_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("results in consecutive cycles");

endmodule

bind roi_max_pooling_top roi_mp_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.pooled_value(rsp.pooled_value),
	.out_channel (rsp.out_channel),
	.bin_row     (rsp.bin_row),
	.bin_col     (rsp.bin_col),
	.last        (rsp.last)
);
